// File: rtl/ogru_pkg.sv
package ogru_pkg;

    // grid geometry
    localparam int GRID_WIDTH = 63;
    localparam int HALF_W     = (GRID_WIDTH - 1) / 2;
    localparam int CENTRE     = GRID_WIDTH * HALF_W + HALF_W;
    localparam int CELLS      = GRID_WIDTH * GRID_WIDTH;
    localparam int ADDR_W     = $clog2(CELLS);

    // field widths
    localparam int COORD_W = 7;
    localparam int IDX_W   = 12;
    localparam int LO_W    = 16;
    localparam int PCT_W   = 7;
    localparam int OCC_W   = 12;
    localparam int FREE_W  = 13;
    localparam int UPPER_W = 15;
    localparam int LOWER_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // line walker widths
    localparam int MAG_W = COORD_W;
    localparam int D_W   = COORD_W + 3;
    localparam int CIDX_W = ADDR_W + 2;

    // register reset values
    localparam logic [OCC_W-1:0]          OCC_RESET   = 12'd562;
    localparam logic signed [FREE_W-1:0]  FREE_RESET  = -13'sd104;
    localparam logic [UPPER_W-1:0]        UPPER_RESET = 15'd12800;
    localparam logic signed [LOWER_W-1:0] LOWER_RESET = -16'sd12800;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_INC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_INC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIM = 2'd3;

    // opcodes
    localparam logic OP_RAY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_ADDR,
        ST_UPD,
        ST_PCT
    } t_state;

    // smallest magnitude at which the rounded percentage reaches 51 + i
    localparam int PCT_N = 50;
    localparam logic [10:0] PCT_STEP [PCT_N] = '{
        11'd6,    11'd16,   11'd26,   11'd36,   11'd47,
        11'd57,   11'd67,   11'd78,   11'd88,   11'd99,
        11'd110,  11'd120,  11'd131,  11'd142,  11'd153,
        11'd165,  11'd176,  11'd188,  11'd199,  11'd211,
        11'd224,  11'd236,  11'd249,  11'd262,  11'd275,
        11'd289,  11'd303,  11'd317,  11'd332,  11'd347,
        11'd363,  11'd380,  11'd397,  11'd416,  11'd435,
        11'd455,  11'd476,  11'd499,  11'd523,  11'd549,
        11'd578,  11'd609,  11'd644,  11'd683,  11'd729,
        11'd783,  11'd850,  11'd938,  11'd1072, 11'd1356
    };

    // clip a 17-bit sum to 16 bits
    function automatic logic signed [LO_W-1:0] sat16(input logic signed [LO_W:0] s);
        logic signed [LO_W-1:0] r;
        if (s > 17'sd32767) begin
            r = 16'sh7FFF;
        end else if (s < -17'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = s[LO_W-1:0];
        end
        return r;
    endfunction

    // rounded logistic percentage by binary search over the threshold table
    function automatic logic [PCT_W-1:0] pct_of(input logic signed [LO_W-1:0] l);
        logic [LO_W:0] a;
        logic [5:0]    pos;
        logic [5:0]    cand;
        logic [PCT_W-1:0] r;
        a   = l[LO_W-1] ? (17'd0 - {l[LO_W-1], l}) : {1'b0, l};
        pos = 6'd0;
        for (int b = 5; b >= 0; b--) begin
            cand = pos + (6'd1 << b);
            if (cand <= 6'(PCT_N) && a >= {6'd0, PCT_STEP[cand - 6'd1]}) begin
                pos = cand;
            end
        end
        if (l[LO_W-1]) begin
            r = 7'd50 - {1'b0, pos};
        end else begin
            r = 7'd50 + {1'b0, pos};
        end
        return r;
    endfunction

endpackage

// File: rtl/occupancy_grid_ray_update_core.sv
// Log-odds occupancy grid with a ray update engine.
// Input channel (i_in_valid / o_in_stall) takes one item per transfer: a ray
// from the robot cell to the end cell with a hit flag, or a read of the robot
// cell. Output channel (o_out_valid / i_out_stall) gives one result per visited
// cell: cell index, log-odds, occupancy percent, last flag and status.
// Configuration is a plain write port (enable, index, data), no read-back.
// After reset the grid memory is swept to zero, one cell a cycle; the input
// stalls until that pass over every cell is done.
// A ray is worked as accept and set-up, then address, update and percent per
// cell, since the grid memory has a registered read; the percent step waits
// while the output register is held. A read item visits only the robot cell
// that way; an out-of-grid robot cell gives one error result at set-up.
// One item is worked on at a time; the input stalls until its last result is
// loaded into the output register. The output register holds a result while
// the receiver stalls, and the walk waits on it, losing nothing.
module occupancy_grid_ray_update_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [ogru_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ogru_pkg::CFG_W-1:0]           i_cfg_data,
    // input items
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_opcode,
    input  logic signed [ogru_pkg::COORD_W-1:0]  i_robot_x,
    input  logic signed [ogru_pkg::COORD_W-1:0]  i_robot_y,
    input  logic signed [ogru_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [ogru_pkg::COORD_W-1:0]  i_end_y,
    input  logic                                 i_hit,
    // results
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [ogru_pkg::IDX_W-1:0]           o_cell_index,
    output logic signed [ogru_pkg::LO_W-1:0]     o_log_odds,
    output logic [ogru_pkg::PCT_W-1:0]           o_occupancy_percent,
    output logic                                 o_last,
    output logic                                 o_status
);

    import ogru_pkg::*;

    localparam logic signed [COORD_W-1:0] HALF_P = COORD_W'(HALF_W);
    localparam logic signed [COORD_W-1:0] HALF_N = -COORD_W'(HALF_W);

    t_state r_state, n_state;

    // configuration registers
    logic [OCC_W-1:0]          r_occ_inc;
    logic signed [FREE_W-1:0]  r_free_inc;
    logic [UPPER_W-1:0]        r_upper;
    logic signed [LOWER_W-1:0] r_lower;

    // item and walker registers
    logic                      r_op;
    logic                      r_hit;
    logic signed [COORD_W-1:0] r_x, r_y, r_ex, r_ey;
    logic signed [COORD_W-1:0] r_sx, r_sy;
    logic                      r_steep;
    logic [MAG_W-1:0]          r_major, r_i;
    logic signed [D_W-1:0]     r_d, r_inc1, r_inc2;
    logic signed [LO_W-1:0]    r_val;
    logic [ADDR_W-1:0]         r_clr;

    // output register
    logic                      r_out_valid;
    logic [IDX_W-1:0]          r_out_index;
    logic signed [LO_W-1:0]    r_out_lo;
    logic [PCT_W-1:0]          r_out_pct;
    logic                      r_out_last;
    logic                      r_out_status;

    // control from the output decode
    logic                      in_xfer;
    logic                      out_free;
    logic                      load_err;
    logic                      load_res;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [LO_W-1:0]           ram_wdata;
    logic [LO_W-1:0]           ram_rdata;

    // set-up arithmetic
    logic                      start_in;
    logic signed [COORD_W-1:0] ex_c, ey_c;
    logic signed [COORD_W:0]   dxs, dys;
    logic [MAG_W-1:0]          ax, ay, major, minor;
    logic                      steep;
    logic signed [D_W-1:0]     inc1, d0, inc2;

    // per-cell arithmetic
    logic signed [CIDX_W-1:0]  idx_s;
    logic [ADDR_W-1:0]         cell_addr;
    logic                      is_last;
    logic signed [LO_W:0]      v_ext;
    logic signed [LO_W-1:0]    nv;
    logic signed [COORD_W-1:0] n_x, n_y;
    logic signed [D_W-1:0]     n_d;

    ogru_ram #(
        .WIDTH (LO_W),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cell_addr),
        .o_rdata (ram_rdata)
    );

    // handshake terms
    assign in_xfer  = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // robot cell check and end clamp
    always_comb begin
        start_in = (r_x >= HALF_N) && (r_x <= HALF_P) && (r_y >= HALF_N) && (r_y <= HALF_P);
        ex_c = (r_ex > HALF_P) ? HALF_P : ((r_ex < HALF_N) ? HALF_N : r_ex);
        ey_c = (r_ey > HALF_P) ? HALF_P : ((r_ey < HALF_N) ? HALF_N : r_ey);
    end

    // line set-up: deltas, major axis and error terms
    always_comb begin
        dxs   = (COORD_W + 1)'(ex_c) - (COORD_W + 1)'(r_x);
        dys   = (COORD_W + 1)'(ey_c) - (COORD_W + 1)'(r_y);
        ax    = dxs[COORD_W] ? MAG_W'(-dxs) : MAG_W'(dxs);
        ay    = dys[COORD_W] ? MAG_W'(-dys) : MAG_W'(dys);
        steep = ay > ax;
        major = steep ? ay : ax;
        minor = steep ? ax : ay;
        inc1  = signed'(D_W'({minor, 1'b0}));
        d0    = inc1 - signed'(D_W'(major));
        inc2  = d0 - signed'(D_W'(major));
    end

    // cell address of the current point
    always_comb begin
        idx_s = CIDX_W'(CENTRE) + CIDX_W'(r_x) - CIDX_W'(r_y) * CIDX_W'(GRID_WIDTH);
        cell_addr = idx_s[ADDR_W-1:0];
        is_last = (r_i == r_major);
    end

    // log-odds update with limits and saturation
    always_comb begin
        v_ext = {ram_rdata[LO_W-1], ram_rdata};
        nv    = signed'(ram_rdata);
        if (r_op == OP_RAY) begin
            if (is_last && r_hit) begin
                if (v_ext < signed'({2'b00, r_upper})) begin
                    nv = sat16(v_ext + signed'({5'd0, r_occ_inc}));
                end
            end else begin
                if (signed'(ram_rdata) > r_lower) begin
                    nv = sat16(v_ext + (LO_W + 1)'(r_free_inc));
                end
            end
        end
    end

    // next point on the line
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_d = r_d;
        if (r_steep) begin
            n_y = r_y + r_sy;
        end else begin
            n_x = r_x + r_sx;
        end
        if (r_d < 0) begin
            n_d = r_d + r_inc1;
        end else begin
            n_d = r_d + r_inc2;
            if (r_steep) begin
                n_x = r_x + r_sx;
            end else begin
                n_y = r_y + r_sy;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (!start_in) begin
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: n_state = ST_UPD;
            ST_UPD:  n_state = ST_PCT;
            ST_PCT: begin
                if (out_free) begin
                    n_state = is_last ? ST_IDLE : ST_ADDR;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output decode
    always_comb begin
        o_in_stall = 1'b1;
        load_err   = 1'b0;
        load_res   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cell_addr;
        ram_wdata  = nv;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            ST_IDLE:  o_in_stall = 1'b0;
            ST_SETUP: load_err = !start_in && out_free;
            ST_UPD:   ram_we = (r_op == OP_RAY);
            ST_PCT:   load_res = out_free;
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // state and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ_inc  <= OCC_RESET;
            r_free_inc <= FREE_RESET;
            r_upper    <= UPPER_RESET;
            r_lower    <= LOWER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OCC_INC:   r_occ_inc  <= i_cfg_data[OCC_W-1:0];
                CFG_FREE_INC:  r_free_inc <= signed'(i_cfg_data[FREE_W-1:0]);
                CFG_UPPER_LIM: r_upper    <= i_cfg_data[UPPER_W-1:0];
                CFG_LOWER_LIM: r_lower    <= signed'(i_cfg_data[LOWER_W-1:0]);
                default: ;
            endcase
        end
    end

    // item capture and line walker
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op  <= i_opcode;
            r_hit <= i_hit;
            r_x   <= i_robot_x;
            r_y   <= i_robot_y;
            r_ex  <= i_end_x;
            r_ey  <= i_end_y;
        end
        if (r_state == ST_SETUP) begin
            r_i     <= '0;
            r_steep <= steep;
            r_sx    <= dxs[COORD_W] ? -COORD_W'(1) : COORD_W'(1);
            r_sy    <= dys[COORD_W] ? -COORD_W'(1) : COORD_W'(1);
            r_major <= (r_op == OP_READ) ? '0 : major;
            r_d     <= d0;
            r_inc1  <= inc1;
            r_inc2  <= inc2;
        end
        if (r_state == ST_UPD) begin
            r_val <= nv;
        end
        if (load_res && !is_last) begin
            r_x <= n_x;
            r_y <= n_y;
            r_d <= n_d;
            r_i <= r_i + MAG_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_err || load_res) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (load_err) begin
            r_out_index  <= '0;
            r_out_lo     <= '0;
            r_out_pct    <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= STAT_ERR;
        end else if (load_res) begin
            r_out_index  <= IDX_W'(cell_addr);
            r_out_lo     <= r_val;
            r_out_pct    <= pct_of(r_val);
            r_out_last   <= is_last;
            r_out_status <= STAT_OK;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_cell_index        = r_out_index;
    assign o_log_odds          = r_out_lo;
    assign o_occupancy_percent = r_out_pct;
    assign o_last              = r_out_last;
    assign o_status            = r_out_status;

endmodule

// File: rtl/ogru_ram.sv
module ogru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/occupancy_grid_ray_update_core_tb.sv
module occupancy_grid_ray_update_core_tb;
    import ogru_pkg::*;

    localparam int QUIET_LIMIT = 20000;

    typedef struct {
        logic                      opcode;
        logic signed [COORD_W-1:0] robot_x;
        logic signed [COORD_W-1:0] robot_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                      hit;
    } t_ray_item;

    typedef struct {
        logic [IDX_W-1:0]       cell_index;
        logic signed [LO_W-1:0] log_odds;
        logic [PCT_W-1:0]       occupancy_percent;
        logic                   last;
        logic                   status;
    } t_cell_result;

    typedef enum {
        FLOW_FREE,
        FLOW_RANDOM,
        FLOW_RUNS
    } t_flow;

    // mirror of the grid: walks each accepted ray and queues the cells it touches, or a read or error result
    class grid_tracker;
        int           grid [CELLS];
        int           occ_inc;
        int           free_inc;
        int           upper_lim;
        int           lower_lim;
        int           mismatches;
        t_cell_result due_cells [$];

        function new();
            foreach (grid[k]) grid[k] = 0;
            occ_inc    = OCC_RESET;
            free_inc   = FREE_RESET;
            upper_lim  = UPPER_RESET;
            lower_lim  = LOWER_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_OCC_INC:   occ_inc = data[OCC_W-1:0];
                CFG_FREE_INC:  free_inc = $signed(data[FREE_W-1:0]);
                CFG_UPPER_LIM: upper_lim = data[UPPER_W-1:0];
                CFG_LOWER_LIM: lower_lim = $signed(data[LOWER_W-1:0]);
                default: ;
            endcase
        endfunction

        function int clip_lo(int s);
            if (s > 32767) return 32767;
            if (s < -32768) return -32768;
            return s;
        endfunction

        function int clamp_coord(int v);
            if (v > HALF_W) return HALF_W;
            if (v < -HALF_W) return -HALF_W;
            return v;
        endfunction

        // count the thresholds that the magnitude has passed
        function int logistic_percent(int lo);
            int mag;
            int n;
            mag = (lo < 0) ? -lo : lo;
            n = 0;
            for (int k = 0; k < PCT_N; k++) begin
                if (mag >= int'(PCT_STEP[k])) n++;
            end
            return (lo < 0) ? 50 - n : 50 + n;
        endfunction

        function void queue_cell(int idx, int lo, bit fin, bit err);
            t_cell_result r;
            r.cell_index        = idx[IDX_W-1:0];
            r.log_odds          = lo[LO_W-1:0];
            r.occupancy_percent = err ? '0 : PCT_W'(logistic_percent(lo));
            r.last              = fin;
            r.status            = err ? STAT_ERR : STAT_OK;
            due_cells.insert(due_cells.size(), r);
        endfunction

        // an input transfer: update the grid and queue the expected cells
        function void note_item(t_ray_item it);
            int  rx, ry, ex, ey, ax, ay, sx, sy;
            int  major, minor, d, inc1, inc2, x, y, c, v, k;
            bit  steep, fin;
            rx = it.robot_x;
            ry = it.robot_y;
            if (rx < -HALF_W || rx > HALF_W || ry < -HALF_W || ry > HALF_W) begin
                queue_cell(0, 0, 1'b1, 1'b1);
                return;
            end
            if (it.opcode == OP_READ) begin
                c = CENTRE + rx - ry * GRID_WIDTH;
                queue_cell(c, grid[c], 1'b1, 1'b0);
                return;
            end
            ex = clamp_coord(it.end_x);
            ey = clamp_coord(it.end_y);
            ax = (ex < rx) ? rx - ex : ex - rx;
            ay = (ey < ry) ? ry - ey : ey - ry;
            sx = (ex < rx) ? -1 : 1;
            sy = (ey < ry) ? -1 : 1;
            steep = ay > ax;
            major = steep ? ay : ax;
            minor = steep ? ax : ay;
            inc1  = 2 * minor;
            d     = inc1 - major;
            inc2  = d - major;
            x = rx;
            y = ry;
            for (k = 0; k <= major; k++) begin
                fin = (k == major);
                if (k > 0) begin
                    if (steep) y += sy; else x += sx;
                    if (d < 0) begin
                        d += inc1;
                    end else begin
                        d += inc2;
                        if (steep) x += sx; else y += sy;
                    end
                end
                c = CENTRE + x - y * GRID_WIDTH;
                if (c < 0 || c >= CELLS) c = 0;
                v = grid[c];
                if (fin && it.hit) begin
                    if (v < upper_lim) v = clip_lo(v + occ_inc);
                end else begin
                    if (v > lower_lim) v = clip_lo(v + free_inc);
                end
                grid[c] = v;
                queue_cell(c, v, fin, 1'b0);
            end
        endfunction

        function void compare_field(string what, int want, int got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
            end
        endfunction

        // an output transfer: compare with the oldest queued cell
        function void check_cell(t_cell_result got);
            t_cell_result want;
            if (due_cells.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual index %0d",
                         $time, got.cell_index);
                return;
            end
            want = due_cells.pop_front();
            compare_field("cell_index", want.cell_index, got.cell_index);
            compare_field("log_odds", want.log_odds, got.log_odds);
            compare_field("occupancy_percent", want.occupancy_percent,
                          got.occupancy_percent);
            compare_field("last", want.last, got.last);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_opcode;
    logic signed [COORD_W-1:0] i_robot_x;
    logic signed [COORD_W-1:0] i_robot_y;
    logic signed [COORD_W-1:0] i_end_x;
    logic signed [COORD_W-1:0] i_end_y;
    logic                      i_hit;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [IDX_W-1:0]          o_cell_index;
    logic signed [LO_W-1:0]    o_log_odds;
    logic [PCT_W-1:0]          o_occupancy_percent;
    logic                      o_last;
    logic                      o_status;

    grid_tracker  trk;
    t_cell_result seen;
    int           burst_left = 0;
    int           hot_x = 0;
    int           hot_y = 0;
    int           quiet_cycles = 0;
    t_flow        flow_mode = FLOW_FREE;
    int           flow_left = 0;
    int           run_left = 0;
    logic         run_stall = 1'b0;

    occupancy_grid_ray_update_core dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: check each transfer, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.cell_index        = o_cell_index;
            seen.log_odds          = o_log_odds;
            seen.occupancy_percent = o_occupancy_percent;
            seen.last              = o_last;
            seen.status            = o_status;
            trk.check_cell(seen);
        end
        if (flow_left == 0) begin
            flow_mode = t_flow'($urandom_range(0, 2));
            flow_left = $urandom_range(50, 400);
        end else begin
            flow_left--;
        end
        case (flow_mode)
            FLOW_FREE: begin
                i_out_stall <= 1'b0;
            end
            FLOW_RANDOM: begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
                if (run_left == 0) begin
                    run_stall = ~run_stall;
                    run_left  = run_stall ? $urandom_range(1, 7) : $urandom_range(1, 3);
                end
                run_left--;
                i_out_stall <= run_stall;
            end
        endcase
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_ray_item make_item(logic op, int rx, int ry, int ex, int ey,
                                            logic hit);
        t_ray_item it;
        it.opcode  = op;
        it.robot_x = rx[COORD_W-1:0];
        it.robot_y = ry[COORD_W-1:0];
        it.end_x   = ex[COORD_W-1:0];
        it.end_y   = ey[COORD_W-1:0];
        it.hit     = hit;
        return it;
    endfunction

    function automatic int off_grid_coord();
        int v;
        v = $urandom_range(HALF_W + 1, 64);
        return $urandom_range(0, 1) ? -v : ((v > 63) ? 63 : v);
    endfunction

    // many short rays around a hot spot, plus random rays, reads and noise
    function automatic t_ray_item random_item();
        t_ray_item it;
        int        pick;
        pick = $urandom_range(0, 99);
        it = make_item(OP_RAY, $urandom_range(0, 2 * HALF_W) - HALF_W,
                       $urandom_range(0, 2 * HALF_W) - HALF_W,
                       $urandom_range(0, 127), $urandom_range(0, 127),
                       1'($urandom_range(0, 1)));
        if (pick < 10) begin
            it.opcode  = 1'($urandom_range(0, 1));
            it.robot_x = COORD_W'($urandom_range(0, 127));
            it.robot_y = COORD_W'($urandom_range(0, 127));
        end else if (pick < 16) begin
            it.opcode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 2))
                0:       it.robot_x = COORD_W'(off_grid_coord());
                1:       it.robot_y = COORD_W'(off_grid_coord());
                default: begin
                    it.robot_x = COORD_W'(off_grid_coord());
                    it.robot_y = COORD_W'(off_grid_coord());
                end
            endcase
        end else if (pick < 26) begin
            it.opcode = OP_READ;
        end else if (pick < 70) begin
            it.robot_x = COORD_W'(hot_x + int'($urandom_range(0, 6)) - 3);
            it.robot_y = COORD_W'(hot_y + int'($urandom_range(0, 6)) - 3);
            it.end_x   = COORD_W'(hot_x + int'($urandom_range(0, 6)) - 3);
            it.end_y   = COORD_W'(hot_y + int'($urandom_range(0, 6)) - 3);
        end
        return it;
    endfunction

    // one input transfer, opening a new burst after a random gap when due
    task automatic drive_item(input t_ray_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_opcode   <= it.opcode;
        i_robot_x  <= it.robot_x;
        i_robot_y  <= it.robot_y;
        i_end_x    <= it.end_x;
        i_end_y    <= it.end_y;
        i_hit      <= it.hit;
        do @(posedge i_clk); while (o_in_stall);
        trk.note_item(it);
    endtask

    task automatic run_random(input int count);
        hot_x = $urandom_range(0, 56) - 28;
        hot_y = $urandom_range(0, 56) - 28;
        repeat (count) drive_item(random_item());
    endtask

    // stop sending and wait for every queued cell, then let the block settle
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        while (trk.due_cells.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value[CFG_W-1:0];
        trk.set_reg(index, value[CFG_W-1:0]);
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int occ, input int free_step, input int upper,
                                 input int lower);
        write_reg(CFG_OCC_INC, occ);
        write_reg(CFG_FREE_INC, free_step);
        write_reg(CFG_UPPER_LIM, upper);
        write_reg(CFG_LOWER_LIM, lower);
        i_cfg_we <= 1'b0;
    endtask

    // stimulus
    initial begin
        trk = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_OCC_INC;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_RAY;
        i_robot_x   <= '0;
        i_robot_y   <= '0;
        i_end_x     <= '0;
        i_end_y     <= '0;
        i_hit       <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part with the reset register values
        drive_item(make_item(OP_READ, 0, 0, 0, 0, 0));
        drive_item(make_item(OP_RAY, 0, 0, 0, 0, 0));
        drive_item(make_item(OP_RAY, 0, 0, 0, 0, 1));
        drive_item(make_item(OP_READ, 0, 0, 0, 0, 0));
        drive_item(make_item(OP_RAY, -31, 31, 31, -31, 1));
        drive_item(make_item(OP_RAY, -31, 0, 31, 0, 0));
        drive_item(make_item(OP_RAY, 0, 31, 0, -31, 1));
        drive_item(make_item(OP_RAY, 0, 0, 63, -64, 1));
        drive_item(make_item(OP_RAY, 0, 0, -64, 63, 0));
        drive_item(make_item(OP_RAY, 3, -2, 8, 17, 1));
        drive_item(make_item(OP_RAY, -5, 4, -25, -3, 0));
        drive_item(make_item(OP_RAY, 31, 31, 63, 63, 1));
        drive_item(make_item(OP_RAY, 32, 0, 0, 0, 1));
        drive_item(make_item(OP_RAY, 0, -32, 5, 5, 0));
        drive_item(make_item(OP_RAY, -64, 63, 0, 0, 1));
        drive_item(make_item(OP_READ, 63, -64, 0, 0, 0));
        drive_item(make_item(OP_READ, -32, 0, 0, 0, 1));
        drive_item(make_item(OP_READ, -31, 31, 0, 0, 0));
        drive_item(make_item(OP_READ, 31, -31, 0, 0, 0));
        drive_item(make_item(OP_READ, 0, 31, -64, -64, 1));
        drive_item(make_item(OP_RAY, 10, 10, 13, 12, 1));
        drive_item(make_item(OP_RAY, -31, -31, 31, 31, 0));
        drain(8);

        // largest steps and widest limits: saturation at both ends
        apply_setting(4095, -4096, 32767, -32768);
        repeat (10) drive_item(make_item(OP_RAY, 5, 5, 5, 5, 1));
        repeat (10) drive_item(make_item(OP_RAY, -5, -5, -5, -5, 0));
        drive_item(make_item(OP_READ, 5, 5, 0, 0, 0));
        drive_item(make_item(OP_READ, -5, -5, 0, 0, 0));
        run_random(80);
        drain(8);

        // zero steps and limits
        apply_setting(0, 0, 0, 0);
        run_random(60);
        drain(8);

        // tight limits so cells stop changing early
        apply_setting(562, -104, 700, -700);
        run_random(100);
        drain(8);

        // random settings
        repeat (2) begin
            apply_setting($urandom_range(0, 4095), -int'($urandom_range(0, 4096)),
                          $urandom_range(0, 32767), -int'($urandom_range(0, 32768)));
            run_random(110);
            drain(8);
        end

        drain(200);
        if (trk.mismatches == 0 && trk.due_cells.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
